// ===== rtl/decimal_factorial_engine_unit_defines.svh =====
// Assertion macros shared by the checker of the decimal factorial engine.
`ifndef DECIMAL_FACTORIAL_ENGINE_UNIT_DEFINES_SVH
`define DECIMAL_FACTORIAL_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication, reset-qualified
`define DFE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset-qualified
`define DFE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dfe_pkg.sv =====
// Types, constants and helpers of the decimal factorial engine.
package dfe_pkg;

  localparam int GROUP_DIGITS = 16;
  localparam int LOAD_DIGITS  = 3;
  localparam int MULT_W       = 7;
  localparam int GCNT_W       = 5;

  typedef logic [3:0] digit_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCAN,
    ST_GATHER
  } state_t;

  // per-cycle command broadcast to every digit cell
  typedef struct packed {
    logic load;
    logic shift_dn;
    logic shift_up;
  } cell_ctl_t;

  // n in three BCD digits, least significant in the low nibble; 0 loads as 1
  function automatic logic [11:0] to_bcd3(input logic [MULT_W-1:0] n);
    logic [MULT_W-1:0] v;
    logic [14:0]       prod;
    logic [3:0]        q1;
    logic [3:0]        d0;
    logic [3:0]        d1;
    logic [3:0]        d2;
    v    = (n == '0) ? MULT_W'(1) : n;
    prod = 15'(v) * 15'd205;           // x*205 >> 11 == x/10 for x below 1029
    q1   = prod[14:11];
    d0   = 4'(v - MULT_W'(q1) * MULT_W'(10));
    if (q1 >= 4'd10) begin
      d2 = 4'd1;
      d1 = q1 - 4'd10;
    end else begin
      d2 = 4'd0;
      d1 = q1;
    end
    return {d2, d1, d0};
  endfunction

endpackage

// ===== rtl/dfe_cell.sv =====
// One decimal digit of the store: load, shift towards the multiplier or rotate up.
module dfe_cell
  import dfe_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  digit_t    load_digit,
  input  digit_t    from_hi,
  input  digit_t    from_lo,
  output digit_t    digit
);

  digit_t digit_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      digit_r <= load_digit;
    end else if (ctl.shift_dn) begin
      digit_r <= from_hi;
    end else if (ctl.shift_up) begin
      digit_r <= from_lo;
    end
  end

  assign digit = digit_r;

endmodule

// ===== rtl/dfe_mac.sv =====
// Digit multiply-accumulate: digit*m + carry split into a decimal digit and carry.
module dfe_mac
  import dfe_pkg::*;
(
  input  digit_t             digit_in,
  input  logic [MULT_W-1:0]  mult,
  input  logic [MULT_W-1:0]  carry_in,
  output digit_t             digit_out,
  output logic [MULT_W-1:0]  carry_out
);

  logic [10:0] prod;
  logic [23:0] recip;
  logic [7:0]  quot;

  assign prod  = 11'(digit_in) * 11'(mult) + 11'(carry_in);
  // x*6554 >> 16 == x/10 for the whole range of prod
  assign recip = 24'(prod) * 24'd6554;
  assign quot  = recip[23:16];

  assign carry_out = quot[MULT_W-1:0];
  assign digit_out = 4'(prod - 11'(quot) * 11'd10);

endmodule

// ===== rtl/decimal_factorial_engine_unit.sv =====
// Decimal factorial engine: n in, n! out as BCD digit groups, MSD first.
//
// Input channel in_valid/in_ready/in_n takes one n (0..127) per transfer;
// in_ready is high only while the engine is idle.  Results leave on
// out_valid/out_ready as groups of up to 16 BCD digits, most significant group
// first, leading zeros suppressed; out_last flags the final group.  Only the
// final group may be short; its digits sit in the low out_digit_count nibbles.
// The digits live in a ring of NUM_DIGITS cells that, unless readout holds,
// shifts one place a cycle past a single digit multiply-accumulate unit.  An
// item is loaded on its transfer, multiplied by n-1 down to 1 a pass at a time,
// scanned past its leading zeros, then read out digit by digit into groups.
// A new n is taken as soon as the final group sits in the output register.
// On a receiver stall, a full group waits, ring frozen, until the output
// register frees.  Synchronous active-low reset returns to idle with no
// result pending; the digit store is reloaded for every item, so it needs no
// clearing after reset.  Digits beyond the store and the top carry are lost.
module decimal_factorial_engine_unit
  import dfe_pkg::*;
#(
  parameter int NUM_DIGITS = 200
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [MULT_W-1:0] in_n,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [63:0]       out_digit_group,
  output logic [4:0]        out_digit_count,
  output logic              out_last
);

  localparam int PW = $clog2(NUM_DIGITS + 1);

  state_t            state_r;
  state_t            state_nxt;
  cell_ctl_t         ctl;
  logic [MULT_W-1:0] mult_r;
  logic [MULT_W-1:0] carry_r;
  logic [PW-1:0]     cnt_r;
  logic [PW-1:0]     rem_r;
  logic [63:0]       acc_r;
  logic [GCNT_W-1:0] gcnt_r;
  logic              out_valid_r;
  logic [63:0]       out_group_r;
  logic [4:0]        out_count_r;
  logic              out_last_r;

  digit_t            digit [NUM_DIGITS];
  digit_t            mac_digit;
  logic [MULT_W-1:0] mac_carry;
  logic [11:0]       load_bcd;
  digit_t            top_digit;
  logic              pass_end;
  logic              top_found;
  logic              group_done;
  logic              out_free;

  assign load_bcd   = to_bcd3(in_n);
  assign top_digit  = digit[NUM_DIGITS-1];
  assign pass_end   = (cnt_r == PW'(NUM_DIGITS - 1));
  assign top_found  = (top_digit != 4'd0) || pass_end;
  assign group_done = (gcnt_r == GCNT_W'(GROUP_DIGITS)) || (rem_r == '0);
  assign out_free   = !out_valid_r || out_ready;

  dfe_mac u_mac (
    .digit_in  (digit[0]),
    .mult      (mult_r),
    .carry_in  (carry_r),
    .digit_out (mac_digit),
    .carry_out (mac_carry)
  );

  for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_cell
    digit_t ld;
    digit_t hi;
    digit_t lo;

    if (k < LOAD_DIGITS) begin : g_ld
      assign ld = load_bcd[4*k +: 4];
    end else begin : g_zero
      assign ld = 4'd0;
    end

    if (k == NUM_DIGITS - 1) begin : g_top
      assign hi = mac_digit;
    end else begin : g_mid
      assign hi = digit[k+1];
    end

    if (k == 0) begin : g_bot
      assign lo = digit[NUM_DIGITS-1];
    end else begin : g_up
      assign lo = digit[k-1];
    end

    dfe_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .load_digit (ld),
      .from_hi    (hi),
      .from_lo    (lo),
      .digit      (digit[k])
    );
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (mult_r == '0) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (top_found) state_nxt = ST_GATHER;
      end
      ST_GATHER: begin
        if (group_done && out_free && (rem_r == '0)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      ST_MUL: begin
        ctl.shift_dn = (mult_r != '0);
      end
      ST_SCAN: begin
        ctl.shift_up = !top_found;
      end
      ST_GATHER: begin
        ctl.shift_up = !group_done;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mult_r  <= '0;
      carry_r <= '0;
      cnt_r   <= '0;
      rem_r   <= '0;
      acc_r   <= '0;
      gcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            mult_r  <= (in_n == '0) ? '0 : in_n - MULT_W'(1);
            carry_r <= '0;
            cnt_r   <= '0;
            acc_r   <= '0;
            gcnt_r  <= '0;
          end
        end
        ST_MUL: begin
          if (mult_r != '0) begin
            if (pass_end) begin
              cnt_r   <= '0;
              carry_r <= '0;
              mult_r  <= mult_r - MULT_W'(1);
            end else begin
              cnt_r   <= cnt_r + PW'(1);
              carry_r <= mac_carry;
            end
          end else begin
            cnt_r <= '0;
          end
        end
        ST_SCAN: begin
          // cnt_r counts skipped leading zeros; an all-zero store still emits one digit
          if (top_found) begin
            rem_r <= PW'(NUM_DIGITS) - cnt_r;
          end else begin
            cnt_r <= cnt_r + PW'(1);
          end
        end
        ST_GATHER: begin
          if (!group_done) begin
            acc_r  <= {acc_r[59:0], top_digit};
            gcnt_r <= gcnt_r + GCNT_W'(1);
            rem_r  <= rem_r - PW'(1);
          end else if (out_free) begin
            acc_r  <= '0;
            gcnt_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_GATHER) && group_done && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_GATHER) && group_done && out_free) begin
      out_group_r <= acc_r;
      out_count_r <= gcnt_r;
      out_last_r  <= (rem_r == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_digit_group = out_group_r;
  assign out_digit_count = out_count_r;
  assign out_last        = out_last_r;

endmodule

// ===== rtl/dfe_checker.sv =====
// Port-level checker for the decimal factorial engine, bound to the top level.
`include "decimal_factorial_engine_unit_defines.svh"

module dfe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [6:0]  in_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_digit_group,
  input logic [4:0]  out_digit_count,
  input logic        out_last
);

  `DFE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_digit_group) && $stable(out_digit_count) && $stable(out_last), "result changed while stalled")

  `DFE_ASSERT_NOW(a_count_range, clk, rst_n, out_valid, (out_digit_count != 5'd0) && (out_digit_count <= 5'd16), "digit count out of range")

  `DFE_ASSERT_NOW(a_full_groups, clk, rst_n, out_valid && !out_last, out_digit_count == 5'd16, "short group before the last")

  `DFE_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready, "new n taken while computing")

endmodule

bind decimal_factorial_engine_unit dfe_checker u_dfe_checker (.*);
